// ===== hdl/kpi_pkg.sv =====
// Shared types and constants for the keyframe position interpolator.
// Depends on nothing; the interpolator and the checker import it.
package kpi_pkg;

  localparam int KEYS_DEF = 64;

  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int TIME_W = 24;
  localparam int VAL_W  = 32;
  localparam int SEG_W  = 6;
  localparam int FAC_W  = 17;
  localparam int QUO_W  = 16;
  localparam int DCNT_W = 4;

  localparam logic [CNT_W-1:0]  KEY_COUNT_RST = 7'd1;
  localparam logic [FAC_W-1:0]  FACTOR_ONE    = 17'h1_0000;
  localparam logic [FAC_W-1:0]  FACTOR_ZERO   = 17'h0_0000;
  localparam logic [DCNT_W-1:0] DIV_LAST      = 4'd15;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_CLS,
    ST_DIV,
    ST_WAIT,
    ST_MUL,
    ST_ACC
  } kpi_state_t;

endpackage

// ===== hdl/kpi_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the keyframe time and value tables.
module kpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/keyframe_position_interpolator.sv =====
// A write word does not make the block busy; it accepts the next word at once.
// A sample word gives its result word after a linear search over the n keys,
// n being key_count clamped to 1..KEYS, the shared divider, the three multiplies,
// and any wait while a stalled earlier result word holds it. The input stalls
// meanwhile, so one sample is in work at a time.
// Reset clears the sequencer, the result valid and key_count (to 1); the tables are not.
module keyframe_position_interpolator #(
  parameter int KEYS = kpi_pkg::KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kpi_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [kpi_pkg::IDX_W-1:0]     in_key_index,
  input  logic [kpi_pkg::TIME_W-1:0]    in_key_time,
  input  logic signed [kpi_pkg::VAL_W-1:0] in_key_x,
  input  logic signed [kpi_pkg::VAL_W-1:0] in_key_y,
  input  logic signed [kpi_pkg::VAL_W-1:0] in_key_z,
  input  logic [kpi_pkg::TIME_W-1:0]    in_sample_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [kpi_pkg::VAL_W-1:0] out_x,
  output logic signed [kpi_pkg::VAL_W-1:0] out_y,
  output logic signed [kpi_pkg::VAL_W-1:0] out_z,
  output logic [kpi_pkg::SEG_W-1:0]     out_segment
);

  import kpi_pkg::*;

  localparam int AW = $clog2(KEYS);

  kpi_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        key_count_r;
  logic [TIME_W-1:0]       t_r, t_nxt;
  logic [TIME_W-1:0]       t0_r, t0_nxt;
  logic [AW-1:0]           last_r, last_nxt, last_c;
  logic [AW-1:0]           j_r, j_nxt;
  logic [AW-1:0]           seg_r, seg_nxt;
  logic [AW-1:0]           nxt_r, nxt_nxt;
  logic signed [TIME_W:0]  num_r, num_nxt;
  logic signed [TIME_W:0]  den_r, den_nxt;
  logic [TIME_W-1:0]       rem_r, rem_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic [DCNT_W-1:0]       cnt_r, cnt_nxt;
  logic [FAC_W-1:0]        factor_r, factor_nxt;
  logic signed [VAL_W-1:0] start_x_r, start_x_nxt;
  logic signed [VAL_W-1:0] start_y_r, start_y_nxt;
  logic signed [VAL_W-1:0] start_z_r, start_z_nxt;
  logic signed [VAL_W:0]   diff_x_r, diff_x_nxt;
  logic signed [VAL_W:0]   diff_y_r, diff_y_nxt;
  logic signed [VAL_W:0]   diff_z_r, diff_z_nxt;
  logic signed [50:0]      prod_r, prod_nxt;
  logic [1:0]              ax_r, ax_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_x_r, out_x_nxt;
  logic signed [VAL_W-1:0] out_y_r, out_y_nxt;
  logic signed [VAL_W-1:0] out_z_r, out_z_nxt;
  logic [SEG_W-1:0]        out_segment_r, out_segment_nxt;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic [TIME_W-1:0]       rd_time;
  logic [2*VAL_W-1:0]      rd_xy;
  logic [VAL_W-1:0]        rd_z;
  logic [31:0]             n_ext;
  logic [31:0]             last_ext;
  logic [31:0]             idx_ext;
  logic [31:0]             seg_ext;
  logic                    slot_free;

  kpi_ram #(.WIDTH(TIME_W), .DEPTH(KEYS)) u_time_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_key_time),
    .rd_addr (rd_addr),
    .rd_data (rd_time)
  );

  kpi_ram #(.WIDTH(2*VAL_W), .DEPTH(KEYS)) u_xy_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_key_y, in_key_x}),
    .rd_addr (rd_addr),
    .rd_data (rd_xy)
  );

  kpi_ram #(.WIDTH(VAL_W), .DEPTH(KEYS)) u_z_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_key_z),
    .rd_addr (rd_addr),
    .rd_data (rd_z)
  );

  always_comb begin
    n_ext = 32'(key_count_r);
    if (n_ext == 32'd0) begin
      n_ext = 32'd1;
    end
    if (n_ext > 32'(KEYS)) begin
      n_ext = 32'(KEYS);
    end
    last_ext = n_ext - 32'd1;
    last_c   = last_ext[AW-1:0];
    idx_ext  = 32'(in_key_index);
    wr_addr  = idx_ext[AW-1:0];
    seg_ext  = 32'(seg_r);
  end

  assign slot_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_SAMPLE) begin
          state_nxt = (last_c == '0) ? ST_F0 : ST_SRD;
        end
      end
      ST_SRD:  state_nxt = ST_SCMP;
      ST_SCMP: begin
        if (t_r < rd_time || j_r == last_r) begin
          state_nxt = ST_F0;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_F0:   state_nxt = ST_F1;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_CLS;
      ST_CLS: begin
        if (num_r <= 0 || den_r <= 0 || num_r >= den_r) begin
          state_nxt = ST_WAIT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (slot_free) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (ax_r == AX_Z) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    logic [TIME_W:0]         sh;
    logic [QUO_W-1:0]        q_new;
    logic signed [VAL_W:0]   dsel;
    logic signed [VAL_W-1:0] ssel;
    logic signed [VAL_W-1:0] sum;

    sh   = {rem_r, 1'b0};
    q_new = quo_r;
    dsel = diff_x_r;
    ssel = start_x_r;
    sum  = '0;

    in_stall = (state_r != ST_IDLE);
    wr_en    = (state_r == ST_IDLE) && in_valid && (in_op == OP_WRITE) &&
               (idx_ext < 32'(KEYS));

    rd_addr         = j_r;
    t_nxt           = t_r;
    t0_nxt          = t0_r;
    last_nxt        = last_r;
    j_nxt           = j_r;
    seg_nxt         = seg_r;
    nxt_nxt         = nxt_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    factor_nxt      = factor_r;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    start_z_nxt     = start_z_r;
    diff_x_nxt      = diff_x_r;
    diff_y_nxt      = diff_y_r;
    diff_z_nxt      = diff_z_r;
    prod_nxt        = prod_r;
    ax_nxt          = ax_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_z_nxt       = out_z_r;
    out_segment_nxt = out_segment_r;
    out_valid_nxt   = out_valid_r && out_stall;

    case (ax_r)
      AX_Y: begin
        dsel = diff_y_r;
        ssel = start_y_r;
      end
      AX_Z: begin
        dsel = diff_z_r;
        ssel = start_z_r;
      end
      default: begin
        dsel = diff_x_r;
        ssel = start_x_r;
      end
    endcase

    case (state_r)
      ST_IDLE: begin
        t_nxt    = in_sample_time;
        last_nxt = last_c;
        j_nxt    = AW'(1);
        seg_nxt  = '0;
        nxt_nxt  = '0;
      end
      ST_SCMP: begin
        if (t_r < rd_time) begin
          seg_nxt = j_r - AW'(1);
          nxt_nxt = j_r;
        end else if (j_r == last_r) begin
          seg_nxt = last_r;
          nxt_nxt = last_r;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_F0: begin
        rd_addr = seg_r;
      end
      ST_F1: begin
        rd_addr     = nxt_r;
        start_x_nxt = rd_xy[VAL_W-1:0];
        start_y_nxt = rd_xy[2*VAL_W-1:VAL_W];
        start_z_nxt = rd_z;
        t0_nxt      = rd_time;
        num_nxt     = $signed({1'b0, t_r}) - $signed({1'b0, rd_time});
      end
      ST_F2: begin
        diff_x_nxt = $signed({rd_xy[VAL_W-1], rd_xy[VAL_W-1:0]}) -
                     $signed({start_x_r[VAL_W-1], start_x_r});
        diff_y_nxt = $signed({rd_xy[2*VAL_W-1], rd_xy[2*VAL_W-1:VAL_W]}) -
                     $signed({start_y_r[VAL_W-1], start_y_r});
        diff_z_nxt = $signed({rd_z[VAL_W-1], rd_z}) -
                     $signed({start_z_r[VAL_W-1], start_z_r});
        den_nxt    = $signed({1'b0, rd_time}) - $signed({1'b0, t0_r});
      end
      ST_CLS: begin
        if (num_r <= 0 || den_r < 0) begin
          factor_nxt = FACTOR_ZERO;
        end else if (den_r == 0 || num_r >= den_r) begin
          factor_nxt = FACTOR_ONE;
        end else begin
          rem_nxt = num_r[TIME_W-1:0];
          quo_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        if (sh >= {1'b0, den_r[TIME_W-1:0]}) begin
          rem_nxt = TIME_W'(sh - {1'b0, den_r[TIME_W-1:0]});
          q_new   = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = sh[TIME_W-1:0];
          q_new   = {quo_r[QUO_W-2:0], 1'b0};
        end
        quo_nxt    = q_new;
        cnt_nxt    = cnt_r + DCNT_W'(1);
        factor_nxt = {1'b0, q_new};
      end
      ST_WAIT: begin
        ax_nxt = AX_X;
      end
      ST_MUL: begin
        prod_nxt = dsel * $signed({1'b0, factor_r});
      end
      ST_ACC: begin
        sum = ssel + prod_r[47:16];
        case (ax_r)
          AX_Y:    out_y_nxt = sum;
          AX_Z:    out_z_nxt = sum;
          default: out_x_nxt = sum;
        endcase
        if (ax_r == AX_Z) begin
          out_valid_nxt   = 1'b1;
          out_segment_nxt = seg_ext[SEG_W-1:0];
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      default: begin
        rd_addr = j_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      key_count_r <= KEY_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        key_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r           <= t_nxt;
    t0_r          <= t0_nxt;
    last_r        <= last_nxt;
    j_r           <= j_nxt;
    seg_r         <= seg_nxt;
    nxt_r         <= nxt_nxt;
    num_r         <= num_nxt;
    den_r         <= den_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    cnt_r         <= cnt_nxt;
    factor_r      <= factor_nxt;
    start_x_r     <= start_x_nxt;
    start_y_r     <= start_y_nxt;
    start_z_r     <= start_z_nxt;
    diff_x_r      <= diff_x_nxt;
    diff_y_r      <= diff_y_nxt;
    diff_z_r      <= diff_z_nxt;
    prod_r        <= prod_nxt;
    ax_r          <= ax_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_z_r       <= out_z_nxt;
    out_segment_r <= out_segment_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_z       = out_z_r;
  assign out_segment = out_segment_r;

endmodule

// ===== hdl/kpi_checker.sv =====
// Port-level assertions for the keyframe position interpolator.
// Depends on kpi_pkg; bound to the top level by the statement at the end.
module kpi_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_op,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [kpi_pkg::VAL_W-1:0] out_x,
  input logic signed [kpi_pkg::VAL_W-1:0] out_y,
  input logic signed [kpi_pkg::VAL_W-1:0] out_z,
  input logic [kpi_pkg::SEG_W-1:0]        out_segment
);

  import kpi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_z) && $stable(out_segment))
    else $error("Stalled result word changed or dropped.");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_SAMPLE |=> in_stall)
    else $error("Block not busy after taking a sample word.");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_WRITE |=> !in_stall)
    else $error("Block became busy after a write word.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result word appeared without a sample in work.");

endmodule

bind keyframe_position_interpolator kpi_checker u_kpi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_op       (in_op),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_x       (out_x),
  .out_y       (out_y),
  .out_z       (out_z),
  .out_segment (out_segment)
);
